[hw/rtl/tcce_pkg.sv]
// shared types, codes and defaults for the text console character engine
package tcce_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // command codes
   localparam logic [2:0] MODE_PUT    = 3'd0;
   localparam logic [2:0] MODE_CLEAR  = 3'd1;
   localparam logic [2:0] MODE_UP     = 3'd2;
   localparam logic [2:0] MODE_DOWN   = 3'd3;
   localparam logic [2:0] MODE_SET    = 3'd4;
   localparam logic [2:0] MODE_READ   = 3'd5;

   // control characters
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LAST  = 8'h7F;

   // register indexes
   localparam logic [1:0] CSR_ATTR   = 2'd0;
   localparam logic [1:0] CSR_SCROLL = 2'd1;
   localparam logic [1:0] CSR_CURSOR = 2'd2;

   localparam logic [7:0]  RESET_ATTR = 8'h07;
   localparam logic [15:0] RESET_CELL = 16'h0720;

   typedef enum logic [1:0] {
      WALK_FILL = 2'd0,
      WALK_UP   = 2'd1,
      WALK_DOWN = 2'd2
   } walk_kind_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] char_code;
      logic [7:0] target_col;
      logic [7:0] target_row;
   } req_type;

   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic        cursor_update;
      logic [10:0] cursor_linear;
      logic [15:0] cell_value;
   } rsp_type;

   typedef struct packed {
      logic          load_req;
      logic          walk_start;
      walk_kind_type walk_kind;
      logic          walk_init;
      logic          walk_step;
      logic          put_exec;
      logic          lin_load;
      logic          rd_issue;
   } cmd_type;

   typedef struct packed {
      logic walk_last;
      logic put_scroll;
   } sts_type;

endpackage

[hw/rtl/tcce_ctrl.sv]
// sequencer for the text console engine: dispatch, cell walks and result strobe
module tcce_ctrl import tcce_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [2:0] req_mode,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   typedef enum logic [5:0] {
      S_START = 6'b000001,
      S_IDLE  = 6'b000010,
      S_PUT   = 6'b000100,
      S_WALK  = 6'b001000,
      S_LIN   = 6'b010000,
      S_READ  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      init_ff, init_in;
   logic      rsp_vld_ff, rsp_vld_in;

   always_comb begin
      state_in   = state_ff;
      init_in    = init_ff;
      rsp_vld_in = 1'b0;
      cmd        = '0;
      cmd.walk_kind = WALK_FILL;
      case (state_ff)
         S_START: begin
            // power-up clearing pass
            cmd.walk_start = 1'b1;
            cmd.walk_kind  = WALK_FILL;
            cmd.walk_init  = 1'b1;
            state_in       = S_WALK;
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               case (req_mode)
                  MODE_PUT: state_in = S_PUT;
                  MODE_CLEAR: begin
                     cmd.walk_start = 1'b1;
                     cmd.walk_kind  = WALK_FILL;
                     state_in       = S_WALK;
                  end
                  MODE_UP: begin
                     cmd.walk_start = 1'b1;
                     cmd.walk_kind  = WALK_UP;
                     state_in       = S_WALK;
                  end
                  MODE_DOWN: begin
                     cmd.walk_start = 1'b1;
                     cmd.walk_kind  = WALK_DOWN;
                     state_in       = S_WALK;
                  end
                  MODE_READ: state_in = S_READ;
                  default:   state_in = S_LIN;
               endcase
            end
         end
         S_PUT: begin
            cmd.put_exec = 1'b1;
            if (sts.put_scroll) begin
               cmd.walk_start = 1'b1;
               cmd.walk_kind  = WALK_UP;
               state_in       = S_WALK;
            end else begin
               state_in = S_LIN;
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_last) begin
               if (init_ff) begin
                  init_in  = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_LIN;
               end
            end
         end
         S_LIN: begin
            cmd.lin_load = 1'b1;
            rsp_vld_in   = 1'b1;
            state_in     = S_IDLE;
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            rsp_vld_in   = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_START;
         init_ff    <= 1'b1;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         init_ff    <= init_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_vld_ff;

endmodule

[hw/rtl/tcce_datapath.sv]
// cell memory, cursor, settings and the character, walk and address logic
module tcce_datapath import tcce_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  req_type    req_data,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output sts_type    sts,
   output rsp_type    rsp_data
);

   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int CELLS = ROWS * COLUMNS;
   localparam int LW    = $clog2(CELLS);

   localparam logic [CW:0]   COL_LIM  = (CW+1)'(COLUMNS);
   localparam logic [CW:0]   COL_ONE  = (CW+1)'(1);
   localparam logic [CW:0]   COL_EIGHT = (CW+1)'(8);
   localparam logic [CW:0]   COL_LOW3 = (CW+1)'(7);
   localparam logic [RW:0]   ROW_LIM  = (RW+1)'(ROWS);
   localparam logic [RW:0]   ROW_ONE  = (RW+1)'(1);
   localparam logic [RW-1:0] ROW_MAX  = RW'(ROWS - 1);
   localparam logic [7:0]    TC_MAX   = 8'(COLUMNS - 1);
   localparam logic [7:0]    TR_MAX   = 8'(ROWS - 1);
   localparam logic [LW-1:0] L_COLS   = LW'(COLUMNS);
   localparam logic [LW-1:0] L_LAST   = LW'(CELLS - 1);
   localparam logic [LW-1:0] L_UPEND  = LW'(CELLS - COLUMNS);
   localparam logic [LW-1:0] L_ONE    = LW'(1);

   logic [15:0] mem [CELLS];
   logic [15:0] mem_rd_ff;

   // settings
   logic [7:0] attr_ff;
   logic       scroll_ff;
   logic       cursor_ff;

   // cursor and item state
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [LW-1:0] lin_ff;
   req_type       req_ff;
   logic          upd_ff;
   logic          cell_sel_ff;

   // walk state
   logic [LW-1:0] wi_ff, wi_in;
   walk_kind_type walk_kind_ff;
   logic          walk_init_ff;
   logic          pw_vld_ff;
   logic [LW-1:0] pw_addr_ff;
   logic          pw_copy_ff;

   logic [15:0]   blank;
   logic [15:0]   walk_blank;
   logic          walk_copy;
   logic          walk_last;
   logic [LW-1:0] walk_src;

   logic [CW-1:0] in_tc, rd_tc;
   logic [RW-1:0] in_tr, rd_tr;
   logic [LW-1:0] rd_lin;
   logic [LW-1:0] lin_calc;

   logic [CW:0]   pcol;
   logic [RW:0]   prow;
   logic          put_we;
   logic [LW-1:0] put_addr;
   logic [15:0]   put_data;
   logic          overflow;
   logic [CW-1:0] put_col;
   logic [RW-1:0] put_row;

   logic          mem_we;
   logic [LW-1:0] mem_waddr;
   logic [15:0]   mem_wdata;
   logic          mem_re;
   logic [LW-1:0] mem_raddr;

   assign blank      = {attr_ff, CH_SPACE};
   assign walk_blank = walk_init_ff ? RESET_CELL : blank;

   // target clamping
   assign in_tc = (req_data.target_col > TC_MAX) ? CW'(TC_MAX) : CW'(req_data.target_col);
   assign in_tr = (req_data.target_row > TR_MAX) ? RW'(TR_MAX) : RW'(req_data.target_row);
   assign rd_tc = (req_ff.target_col > TC_MAX) ? CW'(TC_MAX) : CW'(req_ff.target_col);
   assign rd_tr = (req_ff.target_row > TR_MAX) ? RW'(TR_MAX) : RW'(req_ff.target_row);

   assign rd_lin   = LW'(rd_tr) * L_COLS + LW'(rd_tc);
   assign lin_calc = LW'(row_ff) * L_COLS + LW'(col_ff);

   // walk addressing
   always_comb begin
      walk_copy = 1'b0;
      walk_src  = wi_ff;
      walk_last = (wi_ff == L_LAST);
      wi_in     = wi_ff + L_ONE;
      case (walk_kind_ff)
         WALK_UP: begin
            walk_copy = (wi_ff < L_UPEND);
            walk_src  = wi_ff + L_COLS;
         end
         WALK_DOWN: begin
            walk_copy = (wi_ff >= L_COLS);
            walk_src  = wi_ff - L_COLS;
            walk_last = (wi_ff == '0);
            wi_in     = wi_ff - L_ONE;
         end
         default: begin
            walk_copy = 1'b0;
         end
      endcase
   end

   // character handling
   always_comb begin
      pcol     = {1'b0, col_ff};
      prow     = {1'b0, row_ff};
      put_we   = 1'b0;
      put_addr = lin_ff;
      put_data = blank;
      if (req_ff.char_code == CH_LF) begin
         pcol = '0;
         prow = prow + ROW_ONE;
      end else if (req_ff.char_code == CH_CR) begin
         pcol = '0;
      end else if (req_ff.char_code == CH_TAB) begin
         pcol = (pcol + COL_EIGHT) & ~COL_LOW3;
      end else if (req_ff.char_code == CH_BS) begin
         if (col_ff != '0) begin
            pcol     = pcol - COL_ONE;
            put_we   = 1'b1;
            put_addr = lin_ff - L_ONE;
         end
      end else if (req_ff.char_code >= CH_SPACE && req_ff.char_code <= CH_LAST) begin
         put_we   = 1'b1;
         put_data = {attr_ff, req_ff.char_code};
         pcol     = pcol + COL_ONE;
      end
      // wrap at line end
      if (pcol >= COL_LIM) begin
         pcol = '0;
         prow = prow + ROW_ONE;
      end
      overflow = (prow >= ROW_LIM);
      put_col  = pcol[CW-1:0];
      if (overflow) begin
         put_row = scroll_ff ? ROW_MAX : '0;
      end else begin
         put_row = prow[RW-1:0];
      end
   end

   assign sts.walk_last  = walk_last;
   assign sts.put_scroll = overflow & scroll_ff;

   // memory ports
   always_comb begin
      if (pw_vld_ff) begin
         mem_we    = 1'b1;
         mem_waddr = pw_addr_ff;
         mem_wdata = pw_copy_ff ? mem_rd_ff : walk_blank;
      end else begin
         mem_we    = cmd.put_exec & put_we;
         mem_waddr = put_addr;
         mem_wdata = put_data;
      end
      mem_re    = cmd.rd_issue | (cmd.walk_step & walk_copy);
      mem_raddr = cmd.rd_issue ? rd_lin : walk_src;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_raddr];
      end
   end

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff   <= RESET_ATTR;
         scroll_ff <= 1'b1;
         cursor_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ATTR:   attr_ff   <= csr_wdata;
            CSR_SCROLL: scroll_ff <= csr_wdata[0];
            CSR_CURSOR: cursor_ff <= csr_wdata[0];
            default:    ;
         endcase
      end
   end

   // cursor and walk control
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         lin_ff       <= '0;
         wi_ff        <= '0;
         walk_kind_ff <= WALK_FILL;
         walk_init_ff <= 1'b1;
         pw_vld_ff    <= 1'b0;
      end else begin
         if (cmd.load_req) begin
            if (req_data.mode == MODE_SET) begin
               col_ff <= in_tc;
               row_ff <= in_tr;
            end else if (req_data.mode == MODE_CLEAR) begin
               col_ff <= '0;
               row_ff <= '0;
            end
         end
         if (cmd.put_exec) begin
            col_ff <= put_col;
            row_ff <= put_row;
         end
         if (cmd.lin_load) begin
            lin_ff <= lin_calc;
         end
         if (cmd.walk_start) begin
            wi_ff        <= (cmd.walk_kind == WALK_DOWN) ? L_LAST : '0;
            walk_kind_ff <= cmd.walk_kind;
            walk_init_ff <= cmd.walk_init;
         end else if (cmd.walk_step) begin
            wi_ff <= wi_in;
         end
         pw_vld_ff <= cmd.walk_step;
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      if (cmd.walk_step) begin
         pw_addr_ff <= wi_ff;
         pw_copy_ff <= walk_copy;
      end
      if (cmd.load_req) begin
         req_ff      <= req_data;
         cell_sel_ff <= (req_data.mode == MODE_READ);
         case (req_data.mode)
            MODE_PUT:   upd_ff <= cursor_ff;
            MODE_CLEAR: upd_ff <= 1'b1;
            MODE_SET:   upd_ff <= 1'b1;
            default:    upd_ff <= 1'b0;
         endcase
      end
   end

   assign rsp_data.cursor_col    = 7'(col_ff);
   assign rsp_data.cursor_row    = 5'(row_ff);
   assign rsp_data.cursor_update = upd_ff;
   assign rsp_data.cursor_linear = 11'(lin_ff);
   assign rsp_data.cell_value    = cell_sel_ff ? mem_rd_ff : 16'h0000;

endmodule

[hw/rtl/text_console_char_engine_top.sv]
// text console character engine: top level
// An item is taken when start is high and busy is low; its single result shows on rsp_data
// for one cycle with rsp_valid high and must be taken then, since the receiver cannot stall.
// Set cursor, unused modes and read cell go from dispatch straight to their result state; a
// character put first handles the character and moves the cursor. Clear, scroll up and scroll
// down walk the cell memory one cell per cycle through its single write port, and so does a
// put that scrolls. After reset the block stays busy while every cell is set to blank with
// attribute 7; register writes are taken at any time.
module text_console_char_engine_top import tcce_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_data.mode),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   tcce_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

[test/text_console_char_engine_top_tb.sv]
// self-checking testbench for the text console character engine
module text_console_char_engine_top_tb;
   import tcce_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS  = DEF_COLUMNS;
   localparam int ROWS  = DEF_ROWS;
   localparam int CELLS = COLS * ROWS;
   localparam int unsigned RUN_LIMIT = 20_000_000;

   // modes with no function, the block must leave everything alone
   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;

   class console_shadow;
      logic [15:0] cells [CELLS];
      int unsigned col, row;
      logic [7:0]  attr;
      logic        scroll_en, cursor_en;
      rsp_type     cursor_reports[$];
      int          errors;

      function new();
         foreach (cells[i]) cells[i] = RESET_CELL;
         col = 0;
         row = 0;
         attr = RESET_ATTR;
         scroll_en = 1'b1;
         cursor_en = 1'b1;
         errors = 0;
      endfunction

      function void configure(logic [7:0] a, logic s, logic c);
         attr = a;
         scroll_en = s;
         cursor_en = c;
      endfunction

      function logic [15:0] blank();
         return {attr, CH_SPACE};
      endfunction

      function void shift_up();
         for (int i = 0; i < (ROWS - 1) * COLS; i++) cells[i] = cells[i + COLS];
         for (int i = (ROWS - 1) * COLS; i < CELLS; i++) cells[i] = blank();
      endfunction

      function void shift_down();
         for (int i = CELLS - 1; i >= COLS; i--) cells[i] = cells[i - COLS];
         for (int i = 0; i < COLS; i++) cells[i] = blank();
      endfunction

      function void put(logic [7:0] c);
         case (c)
            CH_LF: begin
               col = 0;
               row++;
            end
            CH_CR: col = 0;
            CH_TAB: col = (col + 8) & ~32'd7;
            CH_BS: if (col > 0) begin
               col--;
               cells[row * COLS + col] = blank();
            end
            default: if (c >= CH_SPACE && c <= CH_LAST) begin
               cells[row * COLS + col] = {attr, c};
               col++;
            end
         endcase
         if (col >= COLS) begin
            col = 0;
            row++;
         end
         // bottom overflow: scroll, or back to the top with scrolling off
         if (row >= ROWS) begin
            if (scroll_en) begin
               shift_up();
               row = ROWS - 1;
            end else begin
               row = 0;
            end
         end
      endfunction

      function void take_command(req_type r);
         int unsigned tc, tr;
         logic        upd;
         logic [15:0] cell_val;
         rsp_type     e;
         tc = (r.target_col > COLS - 1) ? COLS - 1 : r.target_col;
         tr = (r.target_row > ROWS - 1) ? ROWS - 1 : r.target_row;
         upd = 1'b0;
         cell_val = '0;
         case (r.mode)
            MODE_PUT: begin
               put(r.char_code);
               upd = cursor_en;
            end
            MODE_CLEAR: begin
               foreach (cells[i]) cells[i] = blank();
               col = 0;
               row = 0;
               upd = 1'b1;
            end
            MODE_UP: shift_up();
            MODE_DOWN: shift_down();
            MODE_SET: begin
               col = tc;
               row = tr;
               upd = 1'b1;
            end
            MODE_READ: cell_val = cells[tr * COLS + tc];
            default: ;
         endcase
         e.cursor_col = 7'(col);
         e.cursor_row = 5'(row);
         e.cursor_update = upd;
         e.cursor_linear = 11'(row * COLS + col);
         e.cell_value = cell_val;
         cursor_reports.push_back(e);
      endfunction

      function void check_field(string name, logic [15:0] ev, logic [15:0] av);
         if (av !== ev) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, ev, av);
         end
      endfunction

      function void compare_report(rsp_type a);
         rsp_type e;
         if (cursor_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual %h", $time, a);
            return;
         end
         e = cursor_reports.pop_front();
         check_field("cursor_col", e.cursor_col, a.cursor_col);
         check_field("cursor_row", e.cursor_row, a.cursor_row);
         check_field("cursor_update", e.cursor_update, a.cursor_update);
         check_field("cursor_linear", e.cursor_linear, a.cursor_linear);
         check_field("cell_value", e.cell_value, a.cell_value);
      endfunction

      function int pending();
         return cursor_reports.size();
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_ATTR;
   logic [7:0]  csr_wdata = '0;
   int unsigned cycle_count = 0;

   console_shadow shadow;

   text_console_char_engine_top DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("text_console_char_engine_top verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) shadow.compare_report(rsp_data);
   end

   task automatic send_item(input req_type r);
      req_data <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      shadow.take_command(r);
   endtask

   task automatic issue(input logic [2:0] m, input logic [7:0] ch, input logic [7:0] tc,
                        input logic [7:0] tr);
      req_type r;
      r.mode = m;
      r.char_code = ch;
      r.target_col = tc;
      r.target_row = tr;
      send_item(r);
   endtask

   task automatic pause(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // registers only change once the block has drained and finished any cell walk
   task automatic program_regs(input logic [7:0] a, input logic s, input logic c);
      start <= 1'b0;
      while (shadow.pending() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_ATTR;
      csr_wdata <= a;
      @(posedge clock);
      csr_index <= CSR_SCROLL;
      csr_wdata <= {7'd0, s};
      @(posedge clock);
      csr_index <= CSR_CURSOR;
      csr_wdata <= {7'd0, c};
      @(posedge clock);
      csr_we <= 1'b0;
      shadow.configure(a, s, c);
   endtask

   function automatic req_type random_command();
      req_type     r;
      int unsigned pick, pick_ch;
      pick = $urandom_range(999);
      pick_ch = $urandom_range(99);
      r.char_code = 8'($urandom);
      r.target_col = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(COLS - 1));
      r.target_row = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(ROWS - 1));
      if (pick < 720) begin
         r.mode = MODE_PUT;
         // mostly text runs with line control mixed in, a few stray bytes
         if (pick_ch < 78) r.char_code = 8'($urandom_range(CH_SPACE, CH_LAST));
         else if (pick_ch < 84) r.char_code = CH_LF;
         else if (pick_ch < 88) r.char_code = CH_CR;
         else if (pick_ch < 92) r.char_code = CH_TAB;
         else if (pick_ch < 96) r.char_code = CH_BS;
      end else if (pick < 830) begin
         r.mode = MODE_SET;
      end else if (pick < 960) begin
         r.mode = MODE_READ;
      end else if (pick < 968) begin
         r.mode = MODE_CLEAR;
      end else if (pick < 976) begin
         r.mode = MODE_UP;
      end else if (pick < 984) begin
         r.mode = MODE_DOWN;
      end else begin
         r.mode = pick[0] ? MODE_SPARE_A : MODE_SPARE_B;
      end
      return r;
   endfunction

   initial begin
      shadow = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part with the reset settings
      issue(MODE_READ, 8'h00, 8'h00, 8'h00);
      issue(MODE_PUT, 8'h41, 8'h00, 8'h00);
      issue(MODE_PUT, CH_LAST, 8'hFF, 8'hFF);
      issue(MODE_PUT, CH_SPACE, 8'h00, 8'h00);
      issue(MODE_PUT, 8'h80, 8'h00, 8'h00);
      issue(MODE_PUT, 8'hFF, 8'h00, 8'h00);
      issue(MODE_PUT, 8'h00, 8'h00, 8'h00);
      issue(MODE_PUT, 8'h1F, 8'h00, 8'h00);
      issue(MODE_PUT, CH_TAB, 8'h00, 8'h00);
      issue(MODE_PUT, CH_BS, 8'h00, 8'h00);
      issue(MODE_PUT, CH_CR, 8'h00, 8'h00);
      issue(MODE_PUT, CH_BS, 8'h00, 8'h00);
      issue(MODE_PUT, CH_LF, 8'h00, 8'h00);
      // last cell: wrap off the bottom forces a scroll
      issue(MODE_SET, 8'hAA, 8'hFF, 8'hFF);
      issue(MODE_PUT, 8'h5A, 8'h00, 8'h00);
      issue(MODE_READ, 8'h55, 8'hFF, 8'hFF);
      issue(MODE_READ, 8'h00, 8'd79, 8'd23);
      // tab at the end of a line wraps
      issue(MODE_SET, 8'h00, 8'd79, 8'd3);
      issue(MODE_PUT, CH_TAB, 8'h00, 8'h00);
      issue(MODE_SPARE_A, 8'hFF, 8'hFF, 8'hFF);
      issue(MODE_SPARE_B, 8'h41, 8'h10, 8'h05);
      issue(MODE_CLEAR, 8'h41, 8'h00, 8'h00);
      issue(MODE_UP, 8'h00, 8'h00, 8'h00);
      issue(MODE_DOWN, 8'h00, 8'h00, 8'h00);
      issue(MODE_READ, 8'h00, 8'h00, 8'h00);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: program_regs(8'h00, 1'b1, 1'b1);
            1: program_regs(8'hFF, 1'b0, 1'b0);
            2: program_regs(8'h1E, 1'b0, 1'b1);
            3: program_regs(8'hF0, 1'b1, 1'b0);
            default: program_regs(8'($urandom), 1'($urandom), 1'($urandom));
         endcase
         for (int n = 0; n < 275; n++) begin
            send_item(random_command());
            // phase 2 runs back to back
            if (ph != 2 && $urandom_range(99) < 12) pause($urandom_range(1, 3));
         end
      end

      start <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (shadow.errors == 0) begin
         $display("text_console_char_engine_top verification clean");
      end else begin
         $display("text_console_char_engine_top verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_ctrl.sv
hw/rtl/tcce_datapath.sv
hw/rtl/text_console_char_engine_top.sv
test/text_console_char_engine_top_tb.sv
